/* rtl/core/mgsp_pkg.sv */
package mgsp_pkg;

	// Default sizes of the graph store
	localparam int DEF_MAX_VERTICES = 16;
	localparam int DEF_WEIGHT_BITS  = 16;

	// Field widths on the ports
	localparam int OP_BITS       = 3;
	localparam int VTX_BITS      = 4;
	localparam int WIN_BITS      = 16;
	localparam int WOUT_BITS     = 16;
	localparam int DIST_BITS     = 20;
	localparam int VC_BITS       = 5;
	localparam int IN_DATA_BITS  = 24;
	localparam int OUT_DATA_BITS = 40;

	localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
	localparam logic [VC_BITS-1:0]   VC_RESET = 5'd16;

	// Operation codes
	localparam logic [OP_BITS-1:0] OP_CLEAR = 3'd0;
	localparam logic [OP_BITS-1:0] OP_ADD   = 3'd1;
	localparam logic [OP_BITS-1:0] OP_DEL   = 3'd2;
	localparam logic [OP_BITS-1:0] OP_QUERY = 3'd3;
	localparam logic [OP_BITS-1:0] OP_PATH  = 3'd4;

endpackage

/* rtl/core/matrix_graph_shortest_path.sv */
// Add and delete write both matrix entries, query reads one, unknown operations go straight
// to the result; clear writes all MAX_VERTICES*MAX_VERTICES entries, one matrix entry per cycle.
// Shortest path: each selected vertex among the n in use costs one row pass, at most n
// passes; a source or destination out of range goes straight to the result.
// One item is in work at a time; the next is taken while a result waits at the output.
// Reset: async, active low; a MAX_VERTICES*MAX_VERTICES sweep clears the matrix, tready low.
module matrix_graph_shortest_path
	import mgsp_pkg::*;
#(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration: vertex_count
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [VC_BITS-1:0]       cfg_data,
	// input items
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	// source_vertex[3:0], dest_vertex[7:4], edge_weight_in[23:8]
	input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
	// operation[2:0]
	input  logic [OP_BITS-1:0]       s_axis_tuser,
	// result items
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// edge_weight_out[15:0], path_distance[35:16], zero[39:36]
	output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
	// reachable[0]
	output logic                     m_axis_tuser
);

	localparam int VW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CW    = $clog2(MAX_VERTICES + 1);
	localparam int CELLS = MAX_VERTICES * MAX_VERTICES;
	localparam int AW    = $clog2(CELLS);
	localparam int SW    = ((WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS) + 1;
	localparam int PADW  = OUT_DATA_BITS - WOUT_BITS - DIST_BITS;
	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_WR1   = 4'd2;
	localparam logic [3:0] ST_WR2   = 4'd3;
	localparam logic [3:0] ST_QRD   = 4'd4;
	localparam logic [3:0] ST_QRES  = 4'd5;
	localparam logic [3:0] ST_PINIT = 4'd6;
	localparam logic [3:0] ST_RELAX = 4'd7;
	localparam logic [3:0] ST_DRAIN = 4'd8;
	localparam logic [3:0] ST_PICK  = 4'd9;
	localparam logic [3:0] ST_RDST  = 4'd10;
	localparam logic [3:0] ST_RRES  = 4'd11;
	localparam logic [3:0] ST_EMIT  = 4'd12;

	// Matrix memory: {present, weight}; distance memory
	logic [WEIGHT_BITS:0]   wmem [CELLS];
	logic [DIST_BITS-1:0]   dmem [MAX_VERTICES];

	logic [3:0]             state_q;
	logic [AW-1:0]          sweep_q;
	logic                   clr_reply_q;
	logic [VC_BITS-1:0]     vc_q;
	logic [MAX_VERTICES-1:0] reached_q;
	logic [MAX_VERTICES-1:0] visited_q;
	logic [VW-1:0]          j_q;
	logic                   found_q;
	logic                   v_s1;
	logic [VW-1:0]          j_s1;
	logic                   m_tvalid_q;

	logic [OP_BITS-1:0]     op_q;
	logic [VW-1:0]          src_q;
	logic [VW-1:0]          dst_q;
	logic [WEIGHT_BITS-1:0] w_q;
	logic [VW-1:0]          best_q;
	logic [DIST_BITS-1:0]   best_d_q;
	logic [VW-1:0]          nb_q;
	logic [DIST_BITS-1:0]   nbd_q;
	logic [WOUT_BITS-1:0]   res_w_q;
	logic [DIST_BITS-1:0]   res_d_q;
	logic                   res_ok_q;
	logic [WOUT_BITS-1:0]   out_w_q;
	logic [DIST_BITS-1:0]   out_d_q;
	logic                   out_ok_q;

	logic [WEIGHT_BITS:0]   wm_rd_q;
	logic [DIST_BITS-1:0]   dm_rd_q;

	logic [OP_BITS-1:0]     in_op;
	logic [VTX_BITS-1:0]    in_src;
	logic [VTX_BITS-1:0]    in_dst;
	logic [WIN_BITS-1:0]    in_w;
	logic                   in_acc;
	logic                   in_inside;
	logic                   in_path_ok;
	logic [CW-1:0]          n_act;
	logic [VW-1:0]          n_last;
	logic [AW-1:0]          addr_a;
	logic [AW-1:0]          addr_b;
	logic [MAX_VERTICES-1:0] src_bit;

	logic                   wm_we;
	logic [AW-1:0]          wm_waddr;
	logic [WEIGHT_BITS:0]   wm_wdata;
	logic [AW-1:0]          wm_raddr;
	logic                   dm_we;
	logic [VW-1:0]          dm_waddr;
	logic [DIST_BITS-1:0]   dm_wdata;
	logic [VW-1:0]          dm_raddr;

	logic                   w_pres;
	logic [WEIGHT_BITS-1:0] w_val;
	logic [SW-1:0]          sum;
	logic [DIST_BITS-1:0]   cand;
	logic                   upd;
	logic                   new_r;
	logic [DIST_BITS-1:0]   new_d;
	logic                   take_min;
	logic                   emit_go;

	// Unpack the stream fields
	assign in_op  = s_axis_tuser;
	assign in_src = s_axis_tdata[VTX_BITS-1:0];
	assign in_dst = s_axis_tdata[2*VTX_BITS-1:VTX_BITS];
	assign in_w   = s_axis_tdata[2*VTX_BITS+WIN_BITS-1:2*VTX_BITS];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	// Clamp the vertex count to 1 .. MAX_VERTICES
	always_comb begin
		if (vc_q == '0) begin
			n_act = CW'(1);
		end else if (32'(vc_q) > MAX_VERTICES) begin
			n_act = CW'(MAX_VERTICES);
		end else begin
			n_act = CW'(vc_q);
		end
	end
	assign n_last = VW'(n_act - CW'(1));

	assign in_inside  = (32'(in_src) < MAX_VERTICES) && (32'(in_dst) < MAX_VERTICES);
	assign in_path_ok = (32'(in_src) < 32'(n_act)) && (32'(in_dst) < 32'(n_act));

	assign addr_a  = AW'(32'(src_q) * MAX_VERTICES + 32'(dst_q));
	assign addr_b  = AW'(32'(dst_q) * MAX_VERTICES + 32'(src_q));
	assign src_bit = MAX_VERTICES'(1) << src_q;

	// Matrix memory port control
	always_comb begin
		wm_we    = 1'b0;
		wm_waddr = addr_a;
		wm_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				wm_we    = 1'b1;
				wm_waddr = sweep_q;
			end
			ST_WR1, ST_WR2: begin
				wm_we    = 1'b1;
				wm_waddr = (state_q == ST_WR1) ? addr_a : addr_b;
				wm_wdata = (op_q == OP_ADD) ? {1'b1, w_q} : '0;
			end
			default: begin
			end
		endcase
	end
	assign wm_raddr = (state_q == ST_QRD) ? addr_a
		: AW'(32'(best_q) * MAX_VERTICES + 32'(j_q));

	// Relax stage: row entry and distance of vertex j_s1 arrive from memory
	assign w_pres   = wm_rd_q[WEIGHT_BITS];
	assign w_val    = wm_rd_q[WEIGHT_BITS-1:0];
	assign sum      = SW'(best_d_q) + SW'(w_val);
	assign cand     = (sum > SW'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(sum);
	assign upd      = v_s1 && w_pres && (!reached_q[j_s1] || (cand < dm_rd_q));
	assign new_r    = reached_q[j_s1] || w_pres;
	assign new_d    = upd ? cand : dm_rd_q;
	assign take_min = v_s1 && new_r && !visited_q[j_s1] && (!found_q || (new_d < nbd_q));

	// Distance memory port control
	always_comb begin
		dm_we    = upd;
		dm_waddr = j_s1;
		dm_wdata = cand;
		if (state_q == ST_PINIT) begin
			dm_we    = 1'b1;
			dm_waddr = src_q;
			dm_wdata = '0;
		end
	end
	assign dm_raddr = (state_q == ST_RDST) ? dst_q : j_q;

	// Memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (wm_we) begin
			wmem[wm_waddr] <= wm_wdata;
		end
		wm_rd_q <= wmem[wm_raddr];
		if (dm_we) begin
			dmem[dm_waddr] <= dm_wdata;
		end
		dm_rd_q <= dmem[dm_raddr];
	end

	assign emit_go = (state_q == ST_EMIT) && (!m_tvalid_q || m_axis_tready);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			sweep_q     <= '0;
			clr_reply_q <= 1'b0;
			vc_q        <= VC_RESET;
			reached_q   <= '0;
			visited_q   <= '0;
			j_q         <= '0;
			found_q     <= 1'b0;
			v_s1        <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				vc_q <= cfg_data;
			end
			// Hold the result item until it is taken, load a new one on emit
			m_tvalid_q <= emit_go || (m_tvalid_q && !m_axis_tready);
			v_s1 <= (state_q == ST_RELAX);
			if (upd) begin
				reached_q[j_s1] <= 1'b1;
			end
			if (take_min) begin
				found_q <= 1'b1;
			end

			unique case (state_q)
				ST_CLEAR: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == LAST_CELL) begin
						state_q <= clr_reply_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						unique case (in_op)
							OP_CLEAR: begin
								sweep_q     <= '0;
								clr_reply_q <= 1'b1;
								state_q     <= ST_CLEAR;
							end
							OP_ADD, OP_DEL: state_q <= in_inside ? ST_WR1 : ST_EMIT;
							OP_QUERY:       state_q <= in_inside ? ST_QRD : ST_EMIT;
							OP_PATH:        state_q <= in_path_ok ? ST_PINIT : ST_EMIT;
							default:        state_q <= ST_EMIT;
						endcase
					end
				end
				ST_WR1:  state_q <= ST_WR2;
				ST_WR2:  state_q <= ST_EMIT;
				ST_QRD:  state_q <= ST_QRES;
				ST_QRES: state_q <= ST_EMIT;
				ST_PINIT: begin
					reached_q <= src_bit;
					visited_q <= src_bit;
					j_q       <= '0;
					found_q   <= 1'b0;
					state_q   <= ST_RELAX;
				end
				ST_RELAX: begin
					j_q <= j_q + VW'(1);
					if (j_q == n_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_PICK;
				ST_PICK: begin
					if (found_q) begin
						visited_q[nb_q] <= 1'b1;
						j_q             <= '0;
						found_q         <= 1'b0;
						state_q         <= ST_RELAX;
					end else begin
						state_q <= ST_RDST;
					end
				end
				ST_RDST: state_q <= ST_RRES;
				ST_RRES: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		j_s1 <= j_q;
		if (take_min) begin
			nb_q  <= j_s1;
			nbd_q <= new_d;
		end
		if (in_acc) begin
			op_q     <= in_op;
			src_q    <= VW'(in_src);
			dst_q    <= VW'(in_dst);
			w_q      <= WEIGHT_BITS'(in_w);
			res_w_q  <= '0;
			res_d_q  <= '0;
			res_ok_q <= 1'b0;
		end
		if (state_q == ST_QRES) begin
			res_w_q <= w_pres ? WOUT_BITS'(w_val) : '0;
		end
		if (state_q == ST_PINIT) begin
			best_q   <= src_q;
			best_d_q <= '0;
		end
		if ((state_q == ST_PICK) && found_q) begin
			best_q   <= nb_q;
			best_d_q <= nbd_q;
		end
		if (state_q == ST_RRES) begin
			res_ok_q <= reached_q[dst_q];
			res_d_q  <= reached_q[dst_q] ? dm_rd_q : '0;
		end
		if (emit_go) begin
			out_w_q  <= res_w_q;
			out_d_q  <= res_d_q;
			out_ok_q <= res_ok_q;
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = {{PADW{1'b0}}, out_d_q, out_w_q};
	assign m_axis_tuser  = out_ok_q;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
	import mgsp_pkg::*;

	localparam int NV = DEF_MAX_VERTICES;

	// Operation codes the block leaves undefined
	localparam logic [OP_BITS-1:0] OP_RSVD_A = 3'd5;
	localparam logic [OP_BITS-1:0] OP_RSVD_B = 3'd6;
	localparam logic [OP_BITS-1:0] OP_RSVD_C = 3'd7;

	typedef struct packed {
		logic [WOUT_BITS-1:0] weight;
		logic [DIST_BITS-1:0] distance;
		logic                 reach;
	} result_t;

	typedef struct packed {
		logic [OP_BITS-1:0]  op;
		logic [VTX_BITS-1:0] src;
		logic [VTX_BITS-1:0] dst;
		logic [WIN_BITS-1:0] w;
		logic                typed;
		result_t             want;
	} step_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [VC_BITS-1:0]       cfg_data = '0;
	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;
	logic [OP_BITS-1:0]       s_axis_tuser = '0;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_axis_tdata;
	logic                     m_axis_tuser;

	// Graph model: edge flags, weights and the vertex count register
	bit   [NV*NV-1:0]    edge_on;
	logic [WIN_BITS-1:0] edge_weight [NV*NV];
	logic [VC_BITS-1:0]  vc_model;

	result_t expected_results [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off_left = 0;
	int fail_count = 0;
	int items_sent = 0;
	int paths_sent = 0;
	int queries_sent = 0;
	int results_seen = 0;

	step_t directed_steps [25] = '{
		'{OP_QUERY,  4'd0,  4'd0,  16'h0000, 1'b1, {16'h0000, 20'd0, 1'b0}},
		'{OP_PATH,   4'd0,  4'd15, 16'h0000, 1'b1, {16'h0000, 20'd0, 1'b0}},
		'{OP_PATH,   4'd5,  4'd5,  16'h0000, 1'b1, {16'h0000, 20'd0, 1'b1}},
		'{OP_RSVD_A, 4'd15, 4'd15, 16'hFFFF, 1'b1, {16'h0000, 20'd0, 1'b0}},
		'{OP_RSVD_B, 4'd0,  4'd0,  16'h0000, 1'b1, {16'h0000, 20'd0, 1'b0}},
		'{OP_RSVD_C, 4'd15, 4'd15, 16'hFFFF, 1'b1, {16'h0000, 20'd0, 1'b0}},
		'{OP_ADD,    4'd0,  4'd15, 16'hFFFF, 1'b1, {16'h0000, 20'd0, 1'b0}},
		'{OP_QUERY,  4'd15, 4'd0,  16'h0000, 1'b1, {16'hFFFF, 20'd0, 1'b0}},
		'{OP_ADD,    4'd15, 4'd1,  16'hFFFF, 1'b1, {16'h0000, 20'd0, 1'b0}},
		'{OP_PATH,   4'd0,  4'd1,  16'h0000, 1'b1, {16'h0000, 20'd131070, 1'b1}},
		'{OP_ADD,    4'd3,  4'd3,  16'h1234, 1'b1, {16'h0000, 20'd0, 1'b0}},
		'{OP_QUERY,  4'd3,  4'd3,  16'h0000, 1'b1, {16'h1234, 20'd0, 1'b0}},
		'{OP_PATH,   4'd3,  4'd3,  16'h0000, 1'b1, {16'h0000, 20'd0, 1'b1}},
		'{OP_ADD,    4'd2,  4'd4,  16'h0000, 1'b1, {16'h0000, 20'd0, 1'b0}},
		'{OP_QUERY,  4'd4,  4'd2,  16'h0000, 1'b1, {16'h0000, 20'd0, 1'b0}},
		'{OP_PATH,   4'd2,  4'd4,  16'h0000, 1'b0, {16'h0000, 20'd0, 1'b0}},
		'{OP_DEL,    4'd0,  4'd15, 16'hFFFF, 1'b1, {16'h0000, 20'd0, 1'b0}},
		'{OP_QUERY,  4'd0,  4'd15, 16'h0000, 1'b1, {16'h0000, 20'd0, 1'b0}},
		'{OP_PATH,   4'd0,  4'd1,  16'h0000, 1'b0, {16'h0000, 20'd0, 1'b0}},
		'{OP_ADD,    4'd1,  4'd2,  16'd5,    1'b0, {16'h0000, 20'd0, 1'b0}},
		'{OP_ADD,    4'd2,  4'd3,  16'd5,    1'b0, {16'h0000, 20'd0, 1'b0}},
		'{OP_ADD,    4'd1,  4'd3,  16'd20,   1'b0, {16'h0000, 20'd0, 1'b0}},
		'{OP_PATH,   4'd1,  4'd3,  16'h0000, 1'b0, {16'h0000, 20'd0, 1'b0}},
		'{OP_CLEAR,  4'd9,  4'd6,  16'hA5A5, 1'b1, {16'h0000, 20'd0, 1'b0}},
		'{OP_PATH,   4'd15, 4'd1,  16'h0000, 1'b1, {16'h0000, 20'd0, 1'b0}}
	};

	matrix_graph_shortest_path dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	// Clock, 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Stop a hung run
	initial begin
		#10000000;
		$display("Verification failed");
		$finish;
	end

	// Vertex count as the search clamps it
	function automatic int active_vertices();
		if (vc_model == 0)
			return 1;
		if (vc_model > NV)
			return NV;
		return int'(vc_model);
	endfunction

	// Apply one operation to the graph model and return its answer
	function automatic result_t graph_apply(logic [OP_BITS-1:0] op, logic [VTX_BITS-1:0] src,
			logic [VTX_BITS-1:0] dst, logic [WIN_BITS-1:0] w);
		result_t             r;
		int                  a, b, n, best, j, slot;
		bit                  found;
		bit                  reached [NV];
		bit                  settled [NV];
		logic [DIST_BITS-1:0] tent [NV];
		logic [DIST_BITS:0]   sum;
		logic [DIST_BITS-1:0] cand;
		r = '0;
		a = int'(src) * NV + int'(dst);
		b = int'(dst) * NV + int'(src);
		case (op)
			OP_CLEAR: edge_on = '0;
			OP_ADD: begin
				edge_weight[a] = w;
				edge_weight[b] = w;
				edge_on[a] = 1'b1;
				edge_on[b] = 1'b1;
			end
			OP_DEL: begin
				edge_on[a] = 1'b0;
				edge_on[b] = 1'b0;
			end
			OP_QUERY: if (edge_on[a]) r.weight = edge_weight[a];
			OP_PATH: begin
				n = active_vertices();
				if (src < n && dst < n) begin
					for (j = 0; j < NV; j++) begin
						tent[j] = '0;
						reached[j] = 1'b0;
						settled[j] = 1'b0;
					end
					reached[src] = 1'b1;
					for (int round = 0; round < n; round++) begin
						// pick the nearest reached, unsettled vertex, lowest index on ties
						found = 1'b0;
						best = 0;
						for (j = 0; j < n; j++)
							if (reached[j] && !settled[j] && (!found || tent[j] < tent[best])) begin
								best = j;
								found = 1'b1;
							end
						if (!found)
							break;
						settled[best] = 1'b1;
						// relax its row, saturating the sum
						for (j = 0; j < n; j++) begin
							slot = best * NV + j;
							if (edge_on[slot]) begin
								sum = {1'b0, tent[best]} + (DIST_BITS+1)'(edge_weight[slot]);
								cand = sum[DIST_BITS] ? DIST_MAX : sum[DIST_BITS-1:0];
								if (!reached[j] || cand < tent[j]) begin
									tent[j] = cand;
									reached[j] = 1'b1;
								end
							end
						end
					end
					if (reached[dst]) begin
						r.distance = tent[dst];
						r.reach = 1'b1;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic log_failure(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	// Check each result item against the oldest pending answer
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tdata[15:0], m_axis_tdata[35:16], m_axis_tuser};
			results_seen++;
			if (expected_results.size() == 0) begin
				log_failure($sformatf("result item with nothing pending: weight %0h dist %0d reach %0b",
					got.weight, got.distance, got.reach));
			end else begin
				want = expected_results.pop_front();
				if (got.weight !== want.weight || got.distance !== want.distance ||
						got.reach !== want.reach || m_axis_tdata[39:36] !== 4'h0)
					log_failure($sformatf(
						"result %0d: expected weight %0h dist %0d reach %0b, got %0h %0d %0b pad %0h",
						results_seen, want.weight, want.distance, want.reach,
						got.weight, got.distance, got.reach, m_axis_tdata[39:36]));
			end
		end
	end

	// Output backpressure: random stalls, or a counted hold-off
	always @(negedge clk) begin
		if (hold_off_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_off_left = hold_off_left - 1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Offer one item, wait for it to be taken, then record its answer
	task automatic send_op(input logic [OP_BITS-1:0] op, input logic [VTX_BITS-1:0] src,
			input logic [VTX_BITS-1:0] dst, input logic [WIN_BITS-1:0] w,
			input bit typed = 1'b0, input result_t want = '0);
		result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			s_axis_tvalid = 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {w, dst, src};
		s_axis_tuser = op;
		do @(posedge clk); while (!s_axis_tready);
		r = graph_apply(op, src, dst, w);
		if (typed)
			r = want;
		expected_results.push_back(r);
		items_sent++;
		if (op == OP_PATH)
			paths_sent++;
		if (op == OP_QUERY)
			queries_sent++;
	endtask

	// Drop valid and wait until every answer has come back
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_vertex_count(input logic [VC_BITS-1:0] v);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		vc_model = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Mostly vertices inside the search range, sometimes any vertex
	function automatic logic [VTX_BITS-1:0] pick_vertex();
		if ($urandom_range(9) == 0)
			return VTX_BITS'($urandom_range(NV - 1));
		return VTX_BITS'($urandom_range(active_vertices() - 1));
	endfunction

	function automatic logic [WIN_BITS-1:0] pick_weight();
		int k;
		k = $urandom_range(9);
		if (k < 4)
			return WIN_BITS'($urandom_range(7));
		if (k < 8)
			return WIN_BITS'($urandom_range(1000));
		if (k == 8)
			return WIN_BITS'($urandom);
		return '1;
	endfunction

	task automatic send_random_item();
		int                  k;
		logic [OP_BITS-1:0]  op;
		k = $urandom_range(99);
		if (k < 2)
			op = OP_CLEAR;
		else if (k < 4)
			case ($urandom_range(2))
				0: op = OP_RSVD_A;
				1: op = OP_RSVD_B;
				default: op = OP_RSVD_C;
			endcase
		else if (k < 40)
			op = OP_ADD;
		else if (k < 50)
			op = OP_DEL;
		else if (k < 65)
			op = OP_QUERY;
		else
			op = OP_PATH;
		send_op(op, pick_vertex(), pick_vertex(), WIN_BITS'($urandom));
	endtask

	// Variant of the above that carries a chosen weight for edge adds
	task automatic send_random_add_or_other();
		if ($urandom_range(2) == 0)
			send_op(OP_ADD, pick_vertex(), pick_vertex(), pick_weight());
		else
			send_random_item();
	endtask

	int vc_plan [8] = '{1, 0, 16, 31, 5, 17, 9, 16};

	initial begin
		edge_on = '0;
		vc_model = VC_RESET;

		// Hold reset, then release between edges
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed opening at the reset vertex count
		foreach (directed_steps[i])
			send_op(directed_steps[i].op, directed_steps[i].src, directed_steps[i].dst,
				directed_steps[i].w, directed_steps[i].typed, directed_steps[i].want);

		// Random phases, each setting a vertex count and a flow-control mode
		for (int p = 0; p < 8; p++) begin
			drain();
			write_vertex_count(VC_BITS'(vc_plan[p]));
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
				default: begin send_idle_pct = 6; recv_stall_pct = 6; end
			endcase
			for (int i = 0; i < 240; i++) begin
				if (p == 2 && i == 30)
					hold_off_left = 400;
				if (p == 5 && i == 120)
					drain();
				send_random_add_or_other();
			end
		end

		drain();
		repeat (300) @(posedge clk);
		fail_count += expected_results.size();

		$display("Ran %0d items (%0d path searches, %0d edge queries), checked %0d results.",
			items_sent, paths_sent, queries_sent, results_seen);
		$display("Vertex counts 16, 1, 0, 31, 5, 17, 9; gaps, stalls, a long hold-off, a drain.");
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/mgsp_pkg.sv
rtl/core/matrix_graph_shortest_path.sv
test/tb_top.sv
